@@ hdl/ida_pkg.sv @@
`default_nettype none

package ida_pkg;

    // Widths of the binary value and of its decimal form
    localparam int NUM_W       = 32;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int BIT_CNT_W   = $clog2(NUM_W);
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);
    localparam int CHAR_W      = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Default depth of the queue between front and back
    localparam int IDA_QUEUE_DEPTH = 2;

    // Classified item: sign flag and unsigned magnitude
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } ida_item_t;

endpackage

`default_nettype wire

@@ hdl/integer_to_decimal_ascii_unit.sv @@
// Converts a 32-bit number, taken as unsigned or as two's complement according to
// is_signed, into its decimal ASCII characters, most significant digit first, with no
// leading zeros; a negative signed value is preceded by '-', zero gives a single '0',
// and the final character of each number carries last_char. The full range converts
// correctly, including the most negative signed value ("-2147483648", 11 characters).
// A front stage takes each transfer and splits it into sign and magnitude, a short
// queue (QUEUE_DEPTH items) holds classified numbers, and a back stage converts them
// one at a time. The back stage takes an item from the queue, runs a bit-serial
// double-dabble loop over every bit of the magnitude (one binary bit per cycle), drops
// leading zeros (one digit per cycle), and emits the characters one at a time while
// the sink does not stall. Dropped zeros and emitted digits always add up to ten. The
// front can take up to QUEUE_DEPTH + 1 further numbers while one is being converted,
// and a character waiting on out_stall never blocks that.
`default_nettype none

module integer_to_decimal_ascii_unit
    import ida_pkg::*;
#(
    parameter int QUEUE_DEPTH = IDA_QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [NUM_W-1:0]  number,
    input  wire logic              is_signed,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CHAR_W-1:0]      char_code,
    output logic                   last_char
);

    logic      push_valid;
    ida_item_t push_item;
    logic      push_full;
    logic      pop_valid;
    ida_item_t pop_item;
    logic      pop;

    // Front: hold one transfer and classify it
    ida_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .is_signed  (is_signed),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full)
    );

    // Queue: decouple classification from conversion
    ida_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    // Back: convert to BCD and emit characters through an output register
    ida_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

`default_nettype wire

@@ hdl/ida_front.sv @@
`default_nettype none

module ida_front
    import ida_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [NUM_W-1:0] number,
    input  wire logic             is_signed,
    output logic                  push_valid,
    output ida_item_t             push_item,
    input  wire logic             push_full
);

    logic      hold_valid_reg;
    ida_item_t hold_item_reg;
    ida_item_t classified;
    logic      accept;
    logic      push;

    // Split off the sign; negating the most negative value yields its magnitude as unsigned
    always_comb
    begin
        classified.neg = is_signed & number[NUM_W-1];
        classified.mag = classified.neg ? (~number + NUM_W'(1)) : number;
    end

    assign push     = hold_valid_reg && !push_full;
    assign in_stall = hold_valid_reg && push_full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= classified;
        end
    end

    assign push_valid = push;
    assign push_item  = hold_item_reg;

endmodule

`default_nettype wire

@@ hdl/ida_queue.sv @@
`default_nettype none

module ida_queue
    import ida_pkg::*;
#(
    parameter int DEPTH = IDA_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    input  ida_item_t      push_item,
    output logic           push_full,
    output logic           pop_valid,
    output ida_item_t      pop_item,
    input  wire logic      pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ida_item_t              mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_full = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ida_back.sv @@
`default_nettype none

module ida_back
    import ida_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    input  ida_item_t              pop_item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CHAR_W-1:0]      char_code,
    output logic                   last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic                   neg_reg;
    logic [NUM_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [DIGIT_CNT_W-1:0] left_reg;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   emit;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                (bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_EMIT) && out_free;
    assign pop       = (state_reg == ST_IDLE) && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            bit_cnt_reg   <= '0;
            left_reg      <= '0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Drop the character once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        neg_reg     <= pop_item.neg;
                        bin_reg     <= pop_item.mag;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= BIT_CNT_W'(NUM_W - 1);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    // Shift one binary bit into the BCD register
                    bcd_reg     <= {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
                    bin_reg     <= {bin_reg[NUM_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
                    if (bit_cnt_reg == '0)
                    begin
                        left_reg  <= DIGIT_CNT_W'(DIGITS);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    // Drop leading zeros, keeping at least one digit
                    if (top_digit == 4'd0 && left_reg != DIGIT_CNT_W'(1))
                    begin
                        bcd_reg  <= {bcd_reg[BCD_W-5:0], 4'd0};
                        left_reg <= left_reg - DIGIT_CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (neg_reg)
                        begin
                            char_reg <= CHAR_MINUS;
                            last_reg <= 1'b0;
                            neg_reg  <= 1'b0;
                        end
                        else
                        begin
                            char_reg <= CHAR_ZERO + {4'd0, top_digit};
                            last_reg <= (left_reg == DIGIT_CNT_W'(1));
                            bcd_reg  <= {bcd_reg[BCD_W-5:0], 4'd0};
                            left_reg <= left_reg - DIGIT_CNT_W'(1);
                            if (left_reg == DIGIT_CNT_W'(1))
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

@@ dv/ida_ascii_checker.sv @@
// Watches both channels of integer_to_decimal_ascii_unit and checks every character.
// Each accepted number is turned into the characters it should produce. Each accepted
// character is then compared with the oldest of those that are still owed.
module ida_ascii_checker
    import ida_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire logic [NUM_W-1:0] number,
    input  wire logic             is_signed,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic             last_char,
    output int                    mismatches,
    output int                    chars_owed
);

    localparam int unsigned RADIX      = 10;
    localparam int          SHOW_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    ascii_char_t owed_chars[$];
    ascii_char_t oldest;
    int          bad_total;

    // Queue the decimal characters of one number, most significant digit first.
    function automatic void queue_decimal(input logic [NUM_W-1:0] value,
                                          input logic signed_mode);
        logic [NUM_W-1:0] mag;
        logic [3:0]       digit [DIGITS];
        int               ndig;
        ascii_char_t      ch;
        mag  = value;
        ndig = 0;
        if (signed_mode && value[NUM_W-1])
        begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            owed_chars.push_back(ch);
            mag = ~value + 1'b1;
        end
        do
        begin
            digit[ndig] = 4'(mag % RADIX);
            mag         = mag / RADIX;
            ndig++;
        end
        while (mag != 0);
        for (int i = ndig - 1; i >= 0; i--)
        begin
            ch.code = CHAR_ZERO + CHAR_W'(digit[i]);
            ch.last = (i == 0);
            owed_chars.push_back(ch);
        end
    endfunction

    task automatic note_bad(input string what, input ascii_char_t want);
        bad_total++;
        if (bad_total <= SHOW_LIMIT)
            $display("%0t: %s: expected code %0d last %0d, got code %0d last %0d",
                     $realtime, what, want.code, want.last, char_code, last_char);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_chars.delete();
            bad_total  = 0;
            mismatches <= 0;
            chars_owed <= 0;
        end
        else
        begin
            // Compare before queueing: a number taken in this cycle cannot show up yet.
            if (out_valid && !out_stall)
            begin
                if (owed_chars.size() == 0)
                    note_bad("character with nothing owed", '0);
                else
                begin
                    oldest = owed_chars.pop_front();
                    if (oldest.code !== char_code || oldest.last !== last_char)
                        note_bad("character mismatch", oldest);
                end
            end
            if (in_valid && !in_stall)
                queue_decimal(number, is_signed);
            mismatches <= bad_total;
            chars_owed <= owed_chars.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Regression for integer_to_decimal_ascii_unit.
// Feed a directed set of numbers covering the corners of both conversions, then
// a few hundred random ones. The sender offers numbers in bursts with random
// gaps. The sink stalls in changing patterns and once holds off long enough to
// back the block up. The checker instance owns prediction and comparison. This
// module only makes stimulus, watches for a hang and gives the verdict.
module tb;
    import ida_pkg::*;

    // Cycles with no transfer on either side before the run counts as hung
    localparam int IDLE_LIMIT      = 4000;
    // Long sink hold-off, far beyond what the queue and converter can absorb
    localparam int HOLD_OFF_CYCLES = 600;
    // Items sent before the long hold-off starts
    localparam int HOLD_OFF_AFTER  = 120;
    localparam int RANDOM_ITEMS    = 320;
    // Quiet cycles at the end, about one full conversion plus margin
    localparam int DRAIN_CYCLES    = 80;

    typedef enum int {
        SINK_READY,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_PERIODIC
    } sink_mode_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [NUM_W-1:0] number    = '0;
    logic             is_signed = 1'b0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [CHAR_W-1:0] char_code;
    logic             last_char;

    int mismatches;
    int chars_owed;
    int items_sent = 0;
    int burst_left = 0;

    integer_to_decimal_ascii_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .is_signed (is_signed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last_char (last_char)
    );

    ida_ascii_checker ascii_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .is_signed  (is_signed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one number and hold it until the transfer happens. Called at a rising
    // edge. Returns at the edge of the transfer, or at the end of a burst after
    // dropping valid for a random gap. A gap of zero keeps valid high so the next
    // number follows without a bubble.
    task automatic offer_number(input logic [NUM_W-1:0] value, input logic signed_mode);
        int gap;
        in_valid  <= 1'b1;
        number    <= value;
        is_signed <= signed_mode;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            // Mostly no gap, so long gapless stretches occur too
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pick a random number: fully random, spread evenly over digit counts, or near boundaries.
    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned     kind;
        int unsigned     ndig;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned pow;
        logic [NUM_W-1:0] value;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            value = $urandom;
        else if (kind < 7)
        begin
            // Uniform over the digit count, then uniform within it
            ndig = $urandom_range(1, DIGITS);
            pow  = 1;
            repeat (ndig - 1) pow *= 10;
            lo = (ndig == 1) ? 0 : pow;
            hi = pow * 10 - 1;
            if (hi > 64'hFFFF_FFFF)
                hi = 64'hFFFF_FFFF;
            value = NUM_W'(lo + $urandom_range(0, int'(hi - lo)));
        end
        else if (kind == 7)
        begin
            // One below, at, or one above a power of ten
            pow = 1;
            repeat ($urandom_range(0, DIGITS - 1)) pow *= 10;
            value = NUM_W'(pow + $urandom_range(0, 2) - 1);
        end
        else if (kind == 8)
            value = -NUM_W'($urandom_range(1, 1000));
        else
        begin
            case ($urandom_range(0, 3))
                0:       value = '0;
                1:       value = 32'h8000_0000;
                2:       value = 32'hFFFF_FFFF;
                default: value = 32'h7FFF_FFFF;
            endcase
        end
        return value;
    endfunction

    // Sink: stall in random patterns. Once enough numbers have gone in, hold
    // off for a long stretch while the sender keeps offering. This fills the
    // block and stalls its input.
    initial
    begin
        sink_mode_t mode;
        int         span;
        bit         held;
        held = 1'b0;
        forever
        begin
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(40, 300);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                if (!held && items_sent >= HOLD_OFF_AFTER)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    SINK_READY:    out_stall <= 1'b0;
                    SINK_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    SINK_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: out_stall <= ((c % 7) < 3);
                    default:       out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Hang detection: count cycles in which neither channel makes a transfer.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("integer_to_decimal_ascii_unit regression: fail");
        $finish;
    end

    initial
    begin
        burst_left = $urandom_range(1, 16);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: zero, single digits, digit-count boundaries, extremes
        // of both modes, the most negative signed value and alternating bits.
        offer_number(32'd0, 1'b0);
        offer_number(32'd0, 1'b1);
        offer_number(32'd1, 1'b0);
        offer_number(32'd9, 1'b1);
        offer_number(32'd10, 1'b0);
        offer_number(32'd99, 1'b1);
        offer_number(32'd100, 1'b0);
        offer_number(32'hFFFF_FFFF, 1'b0);
        offer_number(32'hFFFF_FFFF, 1'b1);
        offer_number(32'h8000_0000, 1'b1);
        offer_number(32'h8000_0000, 1'b0);
        offer_number(32'h7FFF_FFFF, 1'b1);
        offer_number(32'h7FFF_FFFF, 1'b0);
        offer_number(32'd1000000000, 1'b0);
        offer_number(32'd999999999, 1'b1);
        offer_number(32'hFFFF_FFF6, 1'b1);
        offer_number(32'hFFFF_FFF6, 1'b0);
        offer_number(32'hC465_3600, 1'b1);
        offer_number(32'd123456789, 1'b1);
        offer_number(32'hAAAA_AAAA, 1'b0);
        offer_number(32'h5555_5555, 1'b1);

        repeat (RANDOM_ITEMS)
            offer_number(pick_number(), 1'($urandom_range(0, 1)));
        in_valid <= 1'b0;

        // Wait for every owed character, sampled away from the active edge
        do
            @(negedge clk);
        while (chars_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && chars_owed == 0)
            $display("integer_to_decimal_ascii_unit regression: pass");
        else
            $display("integer_to_decimal_ascii_unit regression: fail");
        $finish;
    end

endmodule
